// File: src/priority_ready_queue_top_defines.svh
// ----------------------------------------------------------------------------
// Priority ready queue assertion macros
// Shared helpers for concurrent checks, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_TOP_DEFINES_SVH
`define PRIORITY_READY_QUEUE_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PRQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define PRQ_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/prq_pkg.sv
// ----------------------------------------------------------------------------
// Priority ready queue package
// Sizes, operation and status codes, and the scan unit control type.
// ----------------------------------------------------------------------------
package prq_pkg;

    // Queue bound and derived widths.
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Item field widths.
    localparam int ID_W      = 16;
    localparam int PRI_W     = 6;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int ENTRY_W   = ID_W + PRI_W;
    localparam int TDATA_W   = ((ENTRY_W + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [PRI_W-1:0] DEFAULT_PRI_RESET = PRI_W'(31);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Control from the sequencer to the compare unit.
    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

endpackage

// File: src/prq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage array and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/prq_scan.sv
// ----------------------------------------------------------------------------
// Priority ready queue compare unit
// Keeps the best entry seen so far; a strict compare keeps the oldest on ties.
// ----------------------------------------------------------------------------
`include "priority_ready_queue_top_defines.svh"

module prq_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  prq_pkg::scan_ctl_t          ctl,
    input  logic [prq_pkg::IDX_W-1:0]   cand_idx,
    input  logic [prq_pkg::ENTRY_W-1:0] cand_entry,
    output logic [prq_pkg::IDX_W-1:0]   best_idx,
    output logic [prq_pkg::ID_W-1:0]    best_id,
    output logic [prq_pkg::PRI_W-1:0]   best_pri
);

    logic                        have_reg;
    logic                        have_next;
    logic [prq_pkg::IDX_W-1:0]   best_idx_reg;
    logic [prq_pkg::ID_W-1:0]    best_id_reg;
    logic [prq_pkg::PRI_W-1:0]   best_pri_reg;
    logic [prq_pkg::PRI_W-1:0]   cand_pri;
    logic                        take;

    // The single comparator decides whether the candidate replaces the best.
    assign cand_pri = cand_entry[prq_pkg::ENTRY_W-1:prq_pkg::ID_W];
    assign take     = ctl.sample && (!have_reg || (cand_pri > best_pri_reg));

    always_comb
    begin
        have_next = have_reg;
        if (ctl.clear)
        begin
            have_next = 1'b0;
        end
        else if (ctl.sample)
        begin
            have_next = 1'b1;
        end
    end

    // Valid flag for the running best.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    // Best entry payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg <= cand_idx;
            best_id_reg  <= cand_entry[prq_pkg::ID_W-1:0];
            best_pri_reg <= cand_pri;
        end
    end

    assign best_idx = best_idx_reg;
    assign best_id  = best_id_reg;
    assign best_pri = best_pri_reg;

    // The best priority never drops while a scan runs.
    `PRQ_ASSERT(a_best_monotonic, (ctl.sample && have_reg && !ctl.clear) |=> (best_pri_reg >= $past(best_pri_reg)), "best priority dropped during a scan")

endmodule

// File: src/priority_ready_queue_top.sv
// An enqueue, or an operation on an empty queue, goes from accept to S_DONE, which raises m_tvalid
// once the output is free. A query over N entries scans them: one entry is read per cycle from the RAM.
// A dequeue adds a close-up pass of one RAM read and write per entry behind the winner;
// the next item can be taken in the cycle after the result loads.
// Reset (rst_n, asynchronous, active low) empties the queue and sets default_priority to 31;
// no clearing pass is needed since only entries below the occupancy are ever read.
// ----------------------------------------------------------------------------
// Priority ready queue
// Bounded ready queue in arrival order with highest-priority dequeue,
// oldest first on ties, built around one RAM and one shared comparator.
// ----------------------------------------------------------------------------
`include "priority_ready_queue_top_defines.svh"

module priority_ready_queue_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [prq_pkg::TDATA_W-1:0]    s_tdata,   // [15:0] task_id, [21:16] task_priority
    input  logic [prq_pkg::OP_W-1:0]       s_tuser,   // [1:0] operation
    // Result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [prq_pkg::TDATA_W-1:0]    m_tdata,   // [15:0] picked_id, [21:16] picked_priority
    output logic [prq_pkg::ST_W-1:0]       m_tuser,   // [1:0] status
    // Configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [prq_pkg::APB_DATA_W-1:0] pwdata,
    output logic [prq_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [prq_pkg::CNT_W-1:0]     occ_reg, occ_next;
    logic [prq_pkg::CNT_W-1:0]     idx_reg, idx_next;
    logic                          pend_reg, pend_next;
    logic [prq_pkg::IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [prq_pkg::OP_W-1:0]      op_reg, op_next;
    logic [prq_pkg::ST_W-1:0]      res_st_reg, res_st_next;
    logic [prq_pkg::ID_W-1:0]      res_id_reg, res_id_next;
    logic [prq_pkg::PRI_W-1:0]     res_pri_reg, res_pri_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_load;
    logic [prq_pkg::ST_W-1:0]      out_st_reg;
    logic [prq_pkg::ID_W-1:0]      out_id_reg;
    logic [prq_pkg::PRI_W-1:0]     out_pri_reg;
    logic [prq_pkg::PRI_W-1:0]     def_pri_reg;

    logic                          in_acc;
    logic                          cfg_wr;
    logic                          wr_en;
    logic [prq_pkg::IDX_W-1:0]     wr_addr;
    logic [prq_pkg::ENTRY_W-1:0]   wr_data;
    logic [prq_pkg::IDX_W-1:0]     rd_addr;
    logic [prq_pkg::ENTRY_W-1:0]   rd_data;
    prq_pkg::scan_ctl_t            scan_ctl;
    logic [prq_pkg::IDX_W-1:0]     best_idx;
    logic [prq_pkg::ID_W-1:0]      best_id;
    logic [prq_pkg::PRI_W-1:0]     best_pri;
    logic                          pass_end;

    // Handshakes.
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // Entry storage.
    prq_ram #(
        .WIDTH (prq_pkg::ENTRY_W),
        .DEPTH (prq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared compare unit.
    prq_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .cand_idx   (pend_idx_reg),
        .cand_entry (rd_data),
        .best_idx   (best_idx),
        .best_id    (best_id),
        .best_pri   (best_pri)
    );

    // A pass ends once every entry was issued and the last read came back.
    assign pass_end = (idx_reg == occ_reg) && !pend_reg;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        op_next        = op_reg;
        res_st_next    = res_st_reg;
        res_id_next    = res_id_reg;
        res_pri_next   = res_pri_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_load       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = occ_reg[prq_pkg::IDX_W-1:0];
        wr_data        = s_tdata[prq_pkg::ENTRY_W-1:0];
        rd_addr        = idx_reg[prq_pkg::IDX_W-1:0];
        scan_ctl       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next      = s_tuser;
                    res_st_next  = prq_pkg::ST_DONE;
                    res_id_next  = '0;
                    res_pri_next = '0;
                    state_next   = S_DONE;
                    if (s_tuser == prq_pkg::OP_ENQUEUE)
                    begin
                        if (occ_reg == prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH))
                        begin
                            res_st_next = prq_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            occ_next = occ_reg + prq_pkg::CNT_W'(1);
                        end
                    end
                    else if ((s_tuser == prq_pkg::OP_DEQUEUE) ||
                             (s_tuser == prq_pkg::OP_QUERY))
                    begin
                        if (occ_reg == '0)
                        begin
                            res_st_next = prq_pkg::ST_EMPTY;
                            if (s_tuser == prq_pkg::OP_QUERY)
                            begin
                                res_pri_next = def_pri_reg;
                            end
                        end
                        else
                        begin
                            idx_next       = '0;
                            scan_ctl.clear = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                scan_ctl.sample = pend_reg;
                if (idx_reg < occ_reg)
                begin
                    idx_next      = idx_reg + prq_pkg::CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[prq_pkg::IDX_W-1:0];
                end
                if (pass_end)
                begin
                    res_pri_next = best_pri;
                    if (op_reg == prq_pkg::OP_QUERY)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        res_id_next = best_id;
                        idx_next    = prq_pkg::CNT_W'(best_idx) + prq_pkg::CNT_W'(1);
                        state_next  = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // Each entry behind the winner moves one place toward the front.
                if (idx_reg < occ_reg)
                begin
                    idx_next      = idx_reg + prq_pkg::CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[prq_pkg::IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_idx_reg - prq_pkg::IDX_W'(1);
                    wr_data = rd_data;
                end
                if (pass_end)
                begin
                    occ_next   = occ_reg - prq_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            def_pri_reg   <= prq_pkg::DEFAULT_PRI_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr && (paddr[2] == 1'b0))
            begin
                def_pri_reg <= pwdata[prq_pkg::PRI_W-1:0];
            end
        end
    end

    // Working and output payload.
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        op_reg       <= op_next;
        res_st_reg   <= res_st_next;
        res_id_reg   <= res_id_next;
        res_pri_reg  <= res_pri_next;
        if (out_load)
        begin
            out_st_reg  <= res_st_reg;
            out_id_reg  <= res_id_reg;
            out_pri_reg <= res_pri_reg;
        end
    end

    // Output packing and register readback.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_st_reg;
    assign m_tdata  = {{(prq_pkg::TDATA_W - prq_pkg::ENTRY_W){1'b0}}, out_pri_reg, out_id_reg};
    assign prdata   = (paddr[2] == 1'b0) ?
                      {{(prq_pkg::APB_DATA_W - prq_pkg::PRI_W){1'b0}}, def_pri_reg} : '0;

    // Occupancy stays within the bound.
    `PRQ_NEVER(a_occ_bound,
        occ_reg > prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH),
        "occupancy above queue depth")
    // Writes land only inside the live region or at the tail.
    `PRQ_ASSERT(a_wr_in_range,
        wr_en |-> (prq_pkg::CNT_W'(wr_addr) <= occ_reg),
        "RAM write beyond the queue tail")
    // A finished dequeue removes exactly one entry.
    `PRQ_ASSERT(a_deq_removes_one,
        ((state_reg == S_SHIFT) && pass_end)
            |=> (occ_reg == $past(occ_reg) - prq_pkg::CNT_W'(1)),
        "dequeue did not remove one entry")

endmodule
